@@ src/tcsg_pkg.sv @@
// tcsg_pkg: shared types and constants of the textured column span generator
// item structs, command and register codes, start unit state and handshake structs
// no dependencies
`default_nettype none

package tcsg_pkg;

    localparam int ACC_W   = 26;
    localparam int TEX_W   = 10;
    localparam int CFG_W   = 11;
    localparam int COORD_W = 12;
    localparam int PERP_W  = 31;
    localparam int WORD_W  = 32;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_t;

    typedef enum logic {
        CFG_TEXTURE_WIDTH  = 1'b0,
        CFG_TEXTURE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_HIT,
        ST_FRAC,
        ST_MUL_TEX,
        ST_DIV,
        ST_DONE
    } unit_state_t;

    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] column_x;
        logic signed [COORD_W-1:0] first_row;
        logic signed [COORD_W-1:0] span_start;
        logic signed [COORD_W-1:0] span_end;
        logic                      hit_side;
        logic signed [WORD_W-1:0]  pos_x;
        logic signed [WORD_W-1:0]  pos_y;
        logic        [PERP_W-1:0]  perp_distance;
        logic signed [WORD_W-1:0]  ray_dir_x;
        logic signed [WORD_W-1:0]  ray_dir_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic        [TEX_W-1:0]   tex_column;
        logic        [TEX_W-1:0]   tex_row;
        logic                      on_screen;
        logic                      last_pixel;
    } out_item_t;

    // start request from the top level to the arithmetic unit
    typedef struct packed {
        logic               start;
        logic [WORD_W-1:0]  pos;
        logic [PERP_W-1:0]  perp;
        logic [WORD_W-1:0]  dir;
        logic               div_en;
        logic [COORD_W-1:0] denom;
    } start_req_t;

    // status and results back from the arithmetic unit
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [TEX_W-1:0] tex_column;
        logic [ACC_W-1:0] row_step;
    } start_rsp_t;

endpackage

`default_nettype wire

@@ src/textured_column_span_generator_top.sv @@
// textured_column_span_generator_top: raycaster wall column pixel walker
// takes start and tick items, emits one pixel item per live tick
// depends on tcsg_pkg and tcsg_start_unit
//
// usage:
//   s_valid/s_ready/s_data carry items; cmd start loads a wall slice, cmd tick
//   asks for the next pixel. m_valid/m_ready/m_data carry pixel items.
//   cfg_we/cfg_index/cfg_wdata write texture width and height, no wait.
// setup and ticks:
//   a start item keeps s_ready low while the shared adder works through the
//   hit product, the fraction step, the texture width product, the row step
//   divide (skipped for an empty span) and the done state.
//   tick items go one per cycle while the setup unit is idle and the output
//   is not stalled; the pixel shows in the output register the cycle after
//   its tick is accepted.
// reset:
//   texture width and height go to 64, no span is live, output is empty.
// stall:
//   a waiting pixel holds in the output register; s_ready drops until it is
//   taken, unless it is taken in the same cycle.
`default_nettype none

module textured_column_span_generator_top #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire tcsg_pkg::in_item_t    s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output tcsg_pkg::out_item_t        m_data,
    input  wire logic                  cfg_we,
    input  wire tcsg_pkg::cfg_index_t  cfg_index,
    input  wire logic [10:0]           cfg_wdata
);
    import tcsg_pkg::*;

    localparam int F = FRACTION_BITS;

    // configuration
    logic [CFG_W-1:0]          tex_width_reg;
    logic [CFG_W-1:0]          tex_height_reg;

    // span state
    logic                      span_active_reg;
    logic signed [COORD_W-1:0] cur_col_reg;
    logic signed [COORD_W-1:0] cur_row_reg;
    logic signed [COORD_W-1:0] end_row_reg;
    logic [TEX_W-1:0]          tex_col_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [ACC_W-1:0]          step_reg;

    // output stage
    logic                      m_valid_reg;
    out_item_t                 out_reg;

    start_req_t                req;
    start_rsp_t                rsp;

    logic                      in_fire, start_fire, tick_fire, emit;
    logic signed [COORD_W:0]   span_len;
    logic                      len_pos, span_ok;
    logic signed [COORD_W:0]   row_inc;
    logic                      last;
    logic                      on_screen;
    logic [CFG_W-1:0]          height_m1;
    logic [ACC_W-1:0]          trow_wide, trow_cap;
    logic [TEX_W-1:0]          tex_row;
    logic [ACC_W:0]            acc_sum;
    logic [ACC_W-1:0]          acc_next;

    // a new item only when the unit is free and the output can take a pixel
    assign s_ready    = !rsp.busy && (!m_valid_reg || m_ready);
    assign in_fire    = s_valid && s_ready;
    assign start_fire = in_fire && (s_data.cmd == CMD_START);
    assign tick_fire  = in_fire && (s_data.cmd == CMD_TICK);

    // span length doubles as the divide denominator
    assign span_len = (COORD_W+1)'(s_data.span_end) - (COORD_W+1)'(s_data.span_start);
    assign len_pos  = !span_len[COORD_W] && (span_len != '0);
    assign span_ok  = len_pos && (s_data.first_row < s_data.span_end);

    always_comb begin
        req.start  = start_fire;
        req.pos    = s_data.hit_side ? s_data.pos_x : s_data.pos_y;
        req.dir    = s_data.hit_side ? s_data.ray_dir_x : s_data.ray_dir_y;
        req.perp   = s_data.perp_distance;
        req.div_en = len_pos;
        req.denom  = span_len[COORD_W-1:0];
    end

    tcsg_start_unit #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_start_unit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req            (req),
        .texture_width  (tex_width_reg),
        .texture_height (tex_height_reg),
        .rsp            (rsp)
    );

    // pixel emit path
    assign emit    = tick_fire && span_active_reg && (cur_row_reg < end_row_reg);
    assign row_inc = (COORD_W+1)'(cur_row_reg) + (COORD_W+1)'(1);
    assign last    = (row_inc >= (COORD_W+1)'(end_row_reg));
    assign on_screen = !cur_col_reg[COORD_W-1]
                    && ($unsigned(cur_col_reg) < COORD_W'(SCREEN_WIDTH))
                    && !cur_row_reg[COORD_W-1]
                    && ($unsigned(cur_row_reg) < COORD_W'(SCREEN_HEIGHT));

    // texture row: integer part of the accumulator, held below the height
    assign height_m1 = tex_height_reg - 1'b1;
    assign trow_wide = ACC_W'(acc_reg[ACC_W-1:F]);
    always_comb begin
        if (tex_height_reg == '0) begin
            trow_cap = '0;
        end else if (trow_wide > ACC_W'(height_m1)) begin
            trow_cap = ACC_W'(height_m1);
        end else begin
            trow_cap = trow_wide;
        end
        tex_row = (|trow_cap[ACC_W-1:TEX_W]) ? '1 : trow_cap[TEX_W-1:0];
    end

    // saturating step add
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, step_reg};
    assign acc_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg <= CFG_W'(64);
            tex_height_reg <= CFG_W'(64);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TEXTURE_WIDTH:  tex_width_reg  <= cfg_wdata;
                CFG_TEXTURE_HEIGHT: tex_height_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_active_reg <= 1'b0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            end_row_reg     <= '0;
            tex_col_reg     <= '0;
            acc_reg         <= '0;
            step_reg        <= '0;
        end else begin
            if (start_fire) begin
                span_active_reg <= span_ok;
                cur_col_reg     <= s_data.column_x;
                cur_row_reg     <= s_data.first_row;
                end_row_reg     <= s_data.span_end;
                acc_reg         <= '0;
            end else if (emit) begin
                acc_reg     <= acc_next;
                cur_row_reg <= row_inc[COORD_W-1:0];
                if (last) span_active_reg <= 1'b0;
            end
            // setup results land after the unit finishes
            if (rsp.done) begin
                tex_col_reg <= rsp.tex_column;
                step_reg    <= rsp.row_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg.pixel_x    <= cur_col_reg;
            out_reg.pixel_y    <= cur_row_reg;
            out_reg.tex_column <= tex_col_reg;
            out_reg.tex_row    <= tex_row;
            out_reg.on_screen  <= on_screen;
            out_reg.last_pixel <= last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

@@ src/tcsg_start_unit.sv @@
// tcsg_start_unit: per-column setup arithmetic on one shared adder
// shift-add multiplies for the texture column, restoring divide for the row step
// depends on tcsg_pkg
`default_nettype none

module tcsg_start_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire tcsg_pkg::start_req_t     req,
    input  wire logic [10:0]              texture_width,
    input  wire logic [10:0]              texture_height,
    output tcsg_pkg::start_rsp_t          rsp
);
    import tcsg_pkg::*;

    localparam int F        = FRACTION_BITS;
    localparam int PW       = 2 * F;
    localparam int MUL_BITS = (PW < PERP_W) ? PW : PERP_W;
    localparam int DW       = F + CFG_W;
    localparam int UW       = (PW > DW) ? PW : DW;
    localparam int CNT_MAX  = (MUL_BITS > DW) ? MUL_BITS : DW;
    localparam int CNT_W    = $clog2(CNT_MAX);
    localparam int QW       = (DW > ACC_W) ? DW : ACC_W;

    unit_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [UW-1:0]        acc_reg, acc_next;
    logic [UW-1:0]        mcand_reg, mcand_next;
    logic [PERP_W-1:0]    mplier_reg, mplier_next;
    logic [F-1:0]         pos_reg, pos_next;
    logic [COORD_W-1:0]   denom_reg, denom_next;
    logic                 div_en_reg, div_en_next;
    logic [COORD_W-1:0]   rem_reg, rem_next;
    logic [DW-1:0]        dvd_reg, dvd_next;
    logic [DW-1:0]        quo_reg, quo_next;
    logic [TEX_W-1:0]     col_reg, col_next;

    // the shared adder
    logic [UW-1:0]        add_a, add_b;
    logic                 add_cin;
    logic [UW:0]          add_sum;

    logic signed [63:0]   dir_wide;
    logic [COORD_W:0]     div_shift;
    logic                 div_ge;
    logic [QW-1:0]        quo_ext;

    assign add_sum   = {1'b0, add_a} + {1'b0, add_b} + (UW+1)'(add_cin);
    assign dir_wide  = 64'(signed'(req.dir));
    assign div_shift = {rem_reg, dvd_reg[DW-1]};
    assign div_ge    = add_sum[UW];
    assign quo_ext   = QW'(quo_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req.start) state_next = ST_MUL_HIT;
            end
            ST_MUL_HIT: begin
                if (cnt_reg == CNT_W'(MUL_BITS - 1)) state_next = ST_FRAC;
            end
            ST_FRAC: begin
                state_next = ST_MUL_TEX;
            end
            ST_MUL_TEX: begin
                if (cnt_reg == CNT_W'(CFG_W - 1)) state_next = div_en_reg ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (cnt_reg == CNT_W'(DW - 1)) state_next = ST_DONE;
            end
            ST_DONE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb begin
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        pos_next    = pos_reg;
        denom_next  = denom_reg;
        div_en_next = div_en_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        quo_next    = quo_reg;
        col_next    = col_reg;
        add_a       = acc_reg;
        add_b       = '0;
        add_cin     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (req.start) begin
                    acc_next    = '0;
                    mcand_next  = dir_wide[UW-1:0];
                    mplier_next = req.perp;
                    pos_next    = req.pos[F-1:0];
                    denom_next  = req.denom;
                    div_en_next = req.div_en;
                    cnt_next    = '0;
                end
            end
            ST_MUL_HIT: begin
                add_b       = mplier_reg[0] ? mcand_reg : '0;
                acc_next    = add_sum[UW-1:0];
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
            end
            ST_FRAC: begin
                // fraction of the hit coordinate, wraps modulo one
                add_a       = UW'(acc_reg[PW-1:F]);
                add_b       = UW'(pos_reg);
                acc_next    = '0;
                mcand_next  = UW'(add_sum[F-1:0]);
                mplier_next = PERP_W'(texture_width);
                cnt_next    = '0;
            end
            ST_MUL_TEX: begin
                add_b       = mplier_reg[0] ? mcand_reg : '0;
                acc_next    = add_sum[UW-1:0];
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                col_next    = add_sum[F+CFG_W-1] ? '1 : add_sum[F+TEX_W-1:F];
                rem_next    = '0;
                dvd_next    = {texture_height, {F{1'b0}}};
                quo_next    = '0;
                cnt_next    = (cnt_reg == CNT_W'(CFG_W - 1)) ? '0 : cnt_reg + 1'b1;
            end
            ST_DIV: begin
                // trial subtract of the span length
                add_a    = UW'(div_shift);
                add_b    = ~UW'(denom_reg);
                add_cin  = 1'b1;
                rem_next = div_ge ? add_sum[COORD_W-1:0] : div_shift[COORD_W-1:0];
                quo_next = {quo_reg[DW-2:0], div_ge};
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        rsp.busy       = (state_reg != ST_IDLE);
        rsp.done       = (state_reg == ST_DONE);
        rsp.tex_column = col_reg;
        if (!div_en_reg) begin
            rsp.row_step = '0;
        end else if (quo_ext > QW'({ACC_W{1'b1}})) begin
            rsp.row_step = '1;
        end else begin
            rsp.row_step = quo_ext[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            div_en_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            div_en_reg <= div_en_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        pos_reg    <= pos_next;
        denom_reg  <= denom_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        quo_reg    <= quo_next;
        col_reg    <= col_next;
    end

endmodule

`default_nettype wire

@@ src/tcsg_checker.sv @@
// tcsg_checker: port-level assertions for the column span generator
// bound to textured_column_span_generator_top; depends on tcsg_pkg
`default_nettype none

module tcsg_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire tcsg_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire tcsg_pkg::out_item_t m_data
);
    import tcsg_pkg::*;

    // a start item occupies the setup unit
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.cmd == CMD_START) |=> !s_ready)
        else $error("input ready right after a start item");

    // a pixel only appears after a tick item
    a_pixel_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_data.cmd == CMD_TICK))
        else $error("pixel item without a tick item");

    // no input taken while a pixel is stuck
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input ready while output stalled");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled pixel item changed");

endmodule

bind textured_column_span_generator_top tcsg_checker u_tcsg_checker (.*);

`default_nettype wire
